// File: sv/fio_pkg.sv
// Shared types and constants for the four-channel FIR filter bank.
// Used by the controller, the datapath, the top level and the checker.
package fio_pkg;

  localparam int TAPS            = 64;
  localparam int CHANNELS        = 4;
  localparam int DATA_W          = 16;
  localparam int CH_W            = 2;
  localparam int TAPF_W          = 6;
  localparam int TAP_FIELD_LIMIT = 1 << TAPF_W;
  localparam int SUM_TAPS        = (TAPS < TAP_FIELD_LIMIT) ? TAPS : TAP_FIELD_LIMIT;
  localparam int TAP_AW          = $clog2(TAPS);
  localparam int PROD_W          = 2 * DATA_W;
  localparam int ACC_W           = PROD_W + $clog2(SUM_TAPS) + 1;
  localparam int FRAC_W          = 15;
  localparam int IN_W            = 24;
  localparam int OUT_W           = CHANNELS * DATA_W;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (FRAC_W - 1));
  localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN  = -(ACC_W'(32768));

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } fio_state_e;

  typedef struct packed {
    logic take;
    logic issue;
    logic load;
  } fio_cmd_t;

  typedef struct packed {
    logic in_sample;
    logic last_issue;
    logic pipe_empty;
    logic out_free;
  } fio_sts_t;

endpackage

// File: sv/fir_one_in_four_out.sv
// Top level of the four-channel FIR filter bank fed by one input stream.
// Depends on fio_pkg, fio_ctrl and fio_dp.
//
// The slave stream carries two kinds of transfer, told apart by s_axis_tuser.
// A coefficient write (tuser high) stores one Q1.15 tap for one channel and
// gives no result; a tap index at or above TAPS is ignored.
// A sample (tuser low) enters the delay line, and the block then sweeps the
// taps with four multiply-accumulate lanes, one tap per cycle, reading the
// history and coefficient RAMs in step. Each channel sum is rounded to nearest,
// shifted down by 15 and saturated to 16 bits.
// The result appears on the master stream once the sweep has run through the
// RAM read, product and accumulator registers and been loaded into the output
// register, and the next sample is taken only after that load.
// s_axis_tready is low during the sweep. The result waits in an output
// register; while the receiver stalls, the next sample may still be taken and
// swept, and only its final load waits for the register to free up.
// Reset clears the delay line to zeros and drops any pending result.
// Coefficients are undefined until written and must all be written first.
module fir_one_in_four_out
  import fio_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // channel[1:0], tap[7:2], value[23:8]
  input  logic             s_axis_tuser,   // op
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata    // out_zero, out_one, out_two, out_three
);

  fio_cmd_t cmd;
  fio_sts_t sts;

  fio_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .sts_i    (sts),
    .s_ready_o(s_axis_tready),
    .cmd_o    (cmd)
  );

  fio_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata),
    .in_op_i    (s_axis_tuser),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

// File: sv/fio_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fio_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/fio_ctrl.sv
// Controller state machine for the FIR filter bank: accept, tap sweep, drain.
// Depends on fio_pkg.
module fio_ctrl
  import fio_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  input  fio_sts_t sts_i,
  output logic     s_ready_o,
  output fio_cmd_t cmd_o
);

  fio_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i && sts_i.in_sample) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts_i.last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts_i.pipe_empty && sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o   = 1'b0;
    cmd_o.take  = 1'b0;
    cmd_o.issue = 1'b0;
    cmd_o.load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.take = s_valid_i;
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
      end
      ST_DRAIN: begin
        cmd_o.load = sts_i.pipe_empty && sts_i.out_free;
      end
      default: begin
        s_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/fio_dp.sv
// Datapath of the FIR filter bank: history and coefficient RAMs, four MAC lanes,
// rounding and saturation, and the output register. Depends on fio_pkg, fio_ram.
module fio_dp
  import fio_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fio_cmd_t         cmd_i,
  output fio_sts_t         sts_o,
  input  logic [IN_W-1:0]  in_data_i,
  input  logic             in_op_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OUT_W-1:0] out_data_o
);

  logic [CH_W-1:0]          in_ch;
  logic [TAPF_W-1:0]        in_tap;
  logic [DATA_W-1:0]        in_value;
  logic                     tap_ok;
  logic                     hist_we;
  logic [TAP_AW-1:0]        wptr_q, wptr_d;
  logic [TAP_AW-1:0]        rptr_q, rptr_d;
  logic [TAP_AW-1:0]        cnt_q, cnt_d;
  logic [TAPS-1:0]          hvalid_q, hvalid_d;
  logic                     hv1_q;
  logic                     v1_q, v2_q;
  logic [DATA_W-1:0]        hist_rdata;
  logic signed [DATA_W-1:0] hist_term;
  logic [DATA_W-1:0]        coef_rdata [CHANNELS];
  logic signed [PROD_W-1:0] prod_q [CHANNELS];
  logic signed [ACC_W-1:0]  acc_q  [CHANNELS];
  logic                     out_valid_q, out_valid_d;
  logic [OUT_W-1:0]         out_data_q;

  function automatic logic [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    logic [DATA_W-1:0]       res;
    r = a + RND_HALF;
    r = r >>> FRAC_W;
    if (r > SAT_MAX) begin
      res = SAT_MAX[DATA_W-1:0];
    end else if (r < SAT_MIN) begin
      res = SAT_MIN[DATA_W-1:0];
    end else begin
      res = r[DATA_W-1:0];
    end
    return res;
  endfunction

  assign in_ch    = in_data_i[CH_W-1:0];
  assign in_tap   = in_data_i[CH_W+TAPF_W-1:CH_W];
  assign in_value = in_data_i[CH_W+TAPF_W+DATA_W-1:CH_W+TAPF_W];
  assign tap_ok   = 32'(in_tap) < TAPS;
  assign hist_we  = cmd_i.take && (in_op_i == OP_SAMPLE);

  always_comb begin
    wptr_d   = wptr_q;
    rptr_d   = rptr_q;
    cnt_d    = cnt_q;
    hvalid_d = hvalid_q;
    if (hist_we) begin
      hvalid_d[wptr_q] = 1'b1;
      rptr_d           = wptr_q;
      cnt_d            = '0;
      wptr_d           = (wptr_q == TAP_AW'(TAPS - 1)) ? '0 : wptr_q + 1'b1;
    end else if (cmd_i.issue) begin
      cnt_d  = cnt_q + 1'b1;
      rptr_d = (rptr_q == '0) ? TAP_AW'(TAPS - 1) : rptr_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q   <= '0;
      rptr_q   <= '0;
      cnt_q    <= '0;
      hvalid_q <= '0;
      hv1_q    <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
    end else begin
      wptr_q   <= wptr_d;
      rptr_q   <= rptr_d;
      cnt_q    <= cnt_d;
      hvalid_q <= hvalid_d;
      hv1_q    <= hvalid_q[rptr_q];
      v1_q     <= cmd_i.issue;
      v2_q     <= v1_q;
    end
  end

  fio_ram #(
    .WIDTH(DATA_W),
    .DEPTH(TAPS)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(wptr_q),
    .wdata_i(in_value),
    .raddr_i(rptr_q),
    .rdata_o(hist_rdata)
  );

  assign hist_term = hv1_q ? $signed(hist_rdata) : '0;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    logic coef_we;

    assign coef_we = cmd_i.take && (in_op_i == OP_COEF) && tap_ok && (in_ch == CH_W'(c));

    fio_ram #(
      .WIDTH(DATA_W),
      .DEPTH(TAPS)
    ) u_coef_ram (
      .clk_i  (clk_i),
      .we_i   (coef_we),
      .waddr_i(TAP_AW'(in_tap)),
      .wdata_i(in_value),
      .raddr_i(cnt_q),
      .rdata_o(coef_rdata[c])
    );

    always_ff @(posedge clk_i) begin
      prod_q[c] <= $signed(coef_rdata[c]) * hist_term;
      if (hist_we) begin
        acc_q[c] <= '0;
      end else if (v2_q) begin
        acc_q[c] <= acc_q[c] + {{(ACC_W-PROD_W){prod_q[c][PROD_W-1]}}, prod_q[c]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int c = 0; c < CHANNELS; c++) begin
        out_data_q[c*DATA_W +: DATA_W] <= round_sat(acc_q[c]);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.in_sample  = (in_op_i == OP_SAMPLE);
  assign sts_o.last_issue = cmd_i.issue && (cnt_q == TAP_AW'(SUM_TAPS - 1));
  assign sts_o.pipe_empty = !v1_q && !v2_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: sv/fio_checker.sv
// Port-level assertions for the FIR filter bank, bound to the top level.
// Depends on fio_pkg and fir_one_in_four_out.
module fio_checker
  import fio_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             s_axis_tuser,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  logic s_xfer;

  assign s_xfer = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Output valid dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("Output data changed while stalled.");

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && (s_axis_tuser == OP_SAMPLE) |=> !s_axis_tready)
    else $error("Input ready during a tap sweep.");

  a_coef_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && (s_axis_tuser == OP_COEF) |=> s_axis_tready)
    else $error("Coefficient write did not return to idle.");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && (s_axis_tuser == OP_SAMPLE) && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("Result appeared right after a sample transfer.");

endmodule

bind fir_one_in_four_out fio_checker u_fio_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// File: bench/fir_bank_checker.sv
// Checker for the four-channel FIR filter bank: watches both stream channels,
// predicts each result from accepted transfers and compares it lane by lane.
// Depends on fio_pkg for widths, tap counts and operation codes.
module fir_bank_checker
  import fio_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic             s_axis_tuser,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [OUT_W-1:0] m_axis_tdata,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [DATA_W-1:0] q15_t;

  typedef struct packed {
    q15_t out_three;
    q15_t out_two;
    q15_t out_one;
    q15_t out_zero;
  } bank_out_t;

  q15_t      delay_line [TAPS];
  q15_t      coef_bank [CHANNELS][TAPS];
  bank_out_t filtered_q [$];
  int        fail_total = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic q15_t round_saturate(input longint acc);
    longint q;
    q = (acc + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
    if (q > 32767) begin
      q = 32767;
    end else if (q < -32768) begin
      q = -32768;
    end
    return q15_t'(q);
  endfunction

  function automatic bank_out_t filter_bank_sums();
    bank_out_t res;
    longint    acc;
    q15_t      lane [CHANNELS];
    for (int c = 0; c < CHANNELS; c++) begin
      acc = 0;
      for (int m = 0; m < SUM_TAPS; m++) begin
        acc += longint'(coef_bank[c][m]) * longint'(delay_line[m]);
      end
      lane[c] = round_saturate(acc);
    end
    res.out_zero  = lane[0];
    res.out_one   = lane[1];
    res.out_two   = lane[2];
    res.out_three = lane[3];
    return res;
  endfunction

  task automatic take_input();
    logic [CH_W-1:0]   ch;
    logic [TAPF_W-1:0] tap;
    q15_t              value;
    ch    = s_axis_tdata[CH_W-1:0];
    tap   = s_axis_tdata[CH_W +: TAPF_W];
    value = s_axis_tdata[CH_W+TAPF_W +: DATA_W];
    if (s_axis_tuser == OP_COEF) begin
      if (int'(tap) < TAPS) begin
        coef_bank[ch][tap] = value;
      end
    end else begin
      for (int m = TAPS - 1; m > 0; m--) begin
        delay_line[m] = delay_line[m-1];
      end
      delay_line[0] = value;
      filtered_q.push_back(filter_bank_sums());
    end
  endtask

  task automatic check_lane(input string lane_name, input q15_t exp_val, input q15_t act_val);
    if (exp_val !== act_val) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, lane_name, exp_val, act_val);
      fail_total++;
    end
  endtask

  task automatic check_result();
    bank_out_t exp_out;
    bank_out_t act_out;
    act_out = m_axis_tdata;
    if (filtered_q.size() == 0) begin
      $display("%0t ns: unexpected result, expected none, got %h", $time, act_out);
      fail_total++;
    end else begin
      exp_out = filtered_q.pop_front();
      check_lane("out_zero", exp_out.out_zero, act_out.out_zero);
      check_lane("out_one", exp_out.out_one, act_out.out_one);
      check_lane("out_two", exp_out.out_two, act_out.out_two);
      check_lane("out_three", exp_out.out_three, act_out.out_three);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < TAPS; m++) begin
        delay_line[m] = '0;
      end
      filtered_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        take_input();
      end
    end
    pending_o    <= filtered_q.size();
    fail_count_o <= fail_total;
  end

endmodule

// File: bench/fir_one_in_four_out_tb.sv
// Top of the testbench for fir_one_in_four_out: clock, reset, stimulus with
// random gaps and stalls, and the final verdict. Depends on fio_pkg, the block
// and fir_bank_checker, which predicts and compares the results.
module fir_one_in_four_out_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fio_pkg::*;

  localparam int RANDOM_ITEMS = 420;
  localparam int LONG_HOLD    = 1500;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  int               fail_count;
  int               pending;
  bit               hold_output = 1'b0;
  bit               steady      = 1'b0;
  int               lane_shift [CHANNELS];

  fir_one_in_four_out i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  fir_bank_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #60ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 20);
    end
    return $urandom_range(50, 200);
  endfunction

  task automatic send_item(input logic op, input logic [CH_W-1:0] ch,
                           input logic [TAPF_W-1:0] tap, input logic signed [DATA_W-1:0] value);
    int gap;
    s_axis_tdata  <= {value, tap, ch};
    s_axis_tuser  <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_sample(input logic signed [DATA_W-1:0] value);
    send_item(OP_SAMPLE, CH_W'($urandom), TAPF_W'($urandom), value);
  endtask

  task automatic wait_results_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] scaled_coef(input int ch);
    logic signed [DATA_W-1:0] raw;
    raw = DATA_W'($urandom);
    return raw >>> lane_shift[ch];
  endfunction

  function automatic logic signed [DATA_W-1:0] random_sample();
    logic signed [DATA_W-1:0] corner [6];
    corner = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh4000, 16'shC000};
    if ($urandom_range(0, 9) == 0) begin
      return corner[$urandom_range(0, 5)];
    end
    return DATA_W'($urandom);
  endfunction

  initial begin
    int on_len;
    int off_len;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_output) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_output = 1'b0;
      end
      m_axis_tready <= 1'b1;
      on_len = $urandom_range(1, 12);
      repeat (on_len) @(posedge clk_i);
      off_len = pick_gap();
      if (off_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (off_len) @(posedge clk_i);
      end
    end
  end

  initial begin
    int ch;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_SAMPLE;
    rst_ni        = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      lane_shift[c] = $urandom_range(6, 14);
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Channel 0 scales the newest sample by the smallest tap so that rounding
    // ties show up, channels 1 and 2 run at full scale in both signs, channel 3
    // gets small random taps.
    for (int m = 0; m < TAPS; m++) begin
      send_item(OP_COEF, 2'd0, TAPF_W'(m), (m == 0) ? 16'sd1 : 16'sd0);
      send_item(OP_COEF, 2'd1, TAPF_W'(m), 16'sh7FFF);
      send_item(OP_COEF, 2'd2, TAPF_W'(m), 16'sh8000);
      send_item(OP_COEF, 2'd3, TAPF_W'(m), scaled_coef(3));
    end

    // Rounding ties in both signs, then saturation at both ends.
    send_sample(16'sh4000);
    send_sample(16'shC000);
    send_sample(-16'sd16385);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    repeat (3) send_sample(16'sh7FFF);
    repeat (3) send_sample(16'sh8000);
    send_item(OP_COEF, 2'd0, 6'd63, 16'sh8000);
    send_item(OP_COEF, 2'd3, 6'd0, 16'sh7FFF);
    send_item(OP_COEF, 2'd1, 6'd0, 16'sd0);
    send_item(OP_COEF, 2'd2, 6'd63, 16'sh7FFF);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sh7FFF);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 320 && i < 380);
      if (i == 150) begin
        hold_output = 1'b1;
      end
      if (i == 250) begin
        s_axis_tvalid <= 1'b0;
        wait_results_drained();
      end
      if (i % 150 == 0) begin
        for (int c = 0; c < CHANNELS; c++) begin
          lane_shift[c] = $urandom_range(0, 14);
        end
      end
      if (i % 200 == 100) begin
        ch = $urandom_range(0, CHANNELS - 1);
        for (int m = 0; m < TAPS; m++) begin
          send_item(OP_COEF, CH_W'(ch), TAPF_W'(m), scaled_coef(ch));
        end
      end
      if ($urandom_range(0, 99) < 78) begin
        send_sample(random_sample());
      end else begin
        ch = $urandom_range(0, CHANNELS - 1);
        send_item(OP_COEF, CH_W'(ch), TAPF_W'($urandom), scaled_coef(ch));
      end
    end
    s_axis_tvalid <= 1'b0;
    steady = 1'b0;

    wait_results_drained();
    repeat (SUM_TAPS + 8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
